>>> hw/rtl/ltkp_pkg.sv
// Shared types, keyword tables and token-matching functions for the lane
// tag keyword parser. No dependencies.
package ltkp_pkg;

    localparam int KW_COUNT   = 15;
    localparam int KW_MAXLEN  = 14;
    localparam int WAYS_W     = 12;
    localparam int POS_W      = 4;
    localparam int TEXT_W     = KW_MAXLEN * 8;

    typedef logic [KW_COUNT-1:0] kw_mask_t;
    typedef logic [POS_W-1:0]    tok_pos_t;
    typedef logic [WAYS_W-1:0]   ways_t;
    typedef logic [7:0]          byte_t;

    // Result of closing a token
    typedef struct packed {
        logic  hit;
        ways_t ways;
    } tok_fin_t;

    // Everything the token unit reports for one item
    typedef struct packed {
        kw_mask_t adv_cand;
        tok_pos_t adv_pos;
        tok_fin_t fin_cur;
        tok_fin_t fin_adv;
    } tok_info_t;

    localparam kw_mask_t CAND_ALL = {KW_COUNT{1'b1}};
    localparam tok_pos_t POS_MAX  = {POS_W{1'b1}};

    localparam byte_t CH_BAR   = 8'h7C;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_UC_A  = 8'h41;
    localparam byte_t CH_UC_Z  = 8'h5A;
    localparam byte_t CASE_OFS = 8'h20;

    // Keyword text, right aligned (last character in the low byte)
    localparam logic [TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        {TEXT_W{1'b0}},
        TEXT_W'("through"),
        TEXT_W'("left"),
        TEXT_W'("right"),
        TEXT_W'("none"),
        TEXT_W'({"sharp_", "left"}),
        TEXT_W'({"slight_", "left"}),
        TEXT_W'({"merge_to_", "right"}),
        TEXT_W'({"merge_to_", "left"}),
        TEXT_W'({"slight_", "right"}),
        TEXT_W'({"sharp_", "right"}),
        TEXT_W'("reverse"),
        TEXT_W'({"next_", "right"}),
        TEXT_W'({"slide_", "left"}),
        TEXT_W'({"slide_", "right"})
    };

    localparam tok_pos_t KW_LEN [KW_COUNT] = '{
        4'd0, 4'd7, 4'd4, 4'd5, 4'd4, 4'd10, 4'd11,
        4'd14, 4'd13, 4'd12, 4'd11, 4'd7, 4'd10, 4'd10, 4'd11
    };

    localparam ways_t KW_BITS [KW_COUNT] = '{
        12'h001, 12'h002, 12'h004, 12'h008, 12'h001, 12'h010, 12'h020,
        12'h040, 12'h080, 12'h100, 12'h200, 12'hC00, 12'h008, 12'h002, 12'h002
    };

    // Character at a position of a keyword; zero past its end
    function automatic byte_t kw_char(input int k, input tok_pos_t pos);
        byte_t ch;
        int    base;
        ch = 8'h00;
        if (pos < KW_LEN[k])
        begin
            base = (int'(KW_LEN[k]) - 1 - int'(pos)) * 8;
            ch   = KW_TEXT[k][base +: 8];
        end
        return ch;
    endfunction

    // Close a token: OR of the bits of every keyword that matches exactly
    function automatic tok_fin_t kw_finish(input kw_mask_t cand, input tok_pos_t pos);
        tok_fin_t fin;
        fin = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (cand[k] && (KW_LEN[k] == pos))
            begin
                fin.hit  = 1'b1;
                fin.ways = fin.ways | KW_BITS[k];
            end
        end
        return fin;
    endfunction

endpackage

>>> hw/rtl/ltkp_token_unit.sv
// Keyword candidate matcher: advances the candidate mask by one byte and
// closes the current or advanced token. Depends on ltkp_pkg.
module ltkp_token_unit (
    input  ltkp_pkg::kw_mask_t  cand,
    input  ltkp_pkg::tok_pos_t  pos,
    input  ltkp_pkg::byte_t     ch,
    output ltkp_pkg::tok_info_t info
);
    import ltkp_pkg::*;

    kw_mask_t keep;
    tok_pos_t pos_inc;

    // One comparator per keyword, character picked by position
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            keep[k] = cand[k] && (pos < KW_LEN[k]) && (kw_char(k, pos) == ch);
        end
    end

    // Position saturates so over-long tokens match nothing
    assign pos_inc = (pos == POS_MAX) ? pos : pos + tok_pos_t'(1);

    assign info.adv_cand = keep;
    assign info.adv_pos  = pos_inc;
    assign info.fin_cur  = kw_finish(cand, pos);
    assign info.fin_adv  = kw_finish(keep, pos_inc);

endmodule

>>> hw/rtl/lane_tag_keyword_parser_core.sv
// Lane tag keyword parser: input register, token unit, result register.
// An accepted item passes through the input register, then the result
// register. Throughput: one item per cycle while the result side takes
// items; the parse state updates once per item.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parse state to an empty token, empty lane, no error, no byte seen.
module lane_tag_keyword_parser_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ltkp_pkg::byte_t    char_byte,
    input  logic               char_present,
    input  logic               string_end,
    output logic               out_valid,
    input  logic               out_ready,
    output ltkp_pkg::ways_t    lane_ways,
    output logic               lane_valid,
    output logic               parse_error,
    output logic               list_end
);
    import ltkp_pkg::*;

    // Input register
    logic     in_vld_reg;
    byte_t    byte_reg;
    logic     present_reg;
    logic     end_reg;

    // Parse state
    kw_mask_t cand_reg,  cand_next;
    tok_pos_t pos_reg,   pos_next;
    ways_t    acc_reg,   acc_next;
    logic     err_reg,   err_next;
    logic     seen_reg,  seen_next;

    // Result register
    logic     out_vld_reg;
    ways_t    ways_reg,  ways_next;
    logic     lvalid_reg, lvalid_next;
    logic     perr_reg,  perr_next;
    logic     lend_reg,  lend_next;
    logic     emit;

    logic      proceed;
    byte_t     ch_low;
    logic      is_sep;
    logic      is_ws;
    logic      active;
    logic      done;
    tok_info_t info;
    tok_fin_t  fin_end;
    tok_fin_t  fin_clr;

    // Handshake: item in the input register moves on when the result slot frees
    assign proceed  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg    <= char_byte;
            present_reg <= char_present;
            end_reg     <= string_end;
        end
    end

    // Byte classification and lowercasing
    always_comb
    begin
        is_sep = (byte_reg == CH_BAR) || (byte_reg == CH_SEMI);
        is_ws  = (byte_reg inside {CH_SPACE, [CH_TAB:CH_CR]});
        ch_low = (byte_reg inside {[CH_UC_A:CH_UC_Z]}) ? byte_reg + CASE_OFS : byte_reg;
    end

    ltkp_token_unit u_token (
        .cand (cand_reg),
        .pos  (pos_reg),
        .ch   (ch_low),
        .info (info)
    );

    assign fin_clr = kw_finish(CAND_ALL, '0);
    assign active  = present_reg && !err_reg;

    // Next parse state and result for the item in the input register
    always_comb
    begin
        cand_next   = cand_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        err_next    = err_reg;
        seen_next   = seen_reg;
        emit        = 1'b0;
        done        = 1'b0;
        ways_next   = '0;
        lvalid_next = 1'b0;
        perr_next   = 1'b0;
        lend_next   = 1'b0;
        fin_end     = info.fin_cur;

        if (active)
        begin
            seen_next = 1'b1;
            if (is_sep)
            begin
                acc_next  = acc_reg | info.fin_cur.ways;
                cand_next = CAND_ALL;
                pos_next  = '0;
                fin_end   = fin_clr;
                if (!info.fin_cur.hit)
                begin
                    err_next = 1'b1;
                end
                else if (byte_reg == CH_BAR)
                begin
                    // Lane closed by a separator
                    emit        = 1'b1;
                    done        = 1'b1;
                    ways_next   = acc_next;
                    lvalid_next = 1'b1;
                    lend_next   = end_reg;
                    acc_next    = '0;
                end
            end
            else if (!is_ws)
            begin
                cand_next = info.adv_cand;
                pos_next  = info.adv_pos;
                fin_end   = info.fin_adv;
            end
        end

        // End of string closes the last lane and clears all state
        if (end_reg && !done)
        begin
            emit      = 1'b1;
            lend_next = 1'b1;
            if (err_next)
            begin
                perr_next = 1'b1;
            end
            else if (seen_next)
            begin
                if (fin_end.hit)
                begin
                    ways_next   = acc_next | fin_end.ways;
                    lvalid_next = 1'b1;
                end
                else
                begin
                    perr_next = 1'b1;
                end
            end
        end

        if (end_reg)
        begin
            cand_next = CAND_ALL;
            pos_next  = '0;
            acc_next  = '0;
            err_next  = 1'b0;
            seen_next = 1'b0;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= CAND_ALL;
            pos_reg  <= '0;
            acc_reg  <= '0;
            err_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end
        else if (proceed)
        begin
            cand_reg <= cand_next;
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            err_reg  <= err_next;
            seen_reg <= seen_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (proceed)
        begin
            out_vld_reg <= emit;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && emit)
        begin
            ways_reg   <= ways_next;
            lvalid_reg <= lvalid_next;
            perr_reg   <= perr_next;
            lend_reg   <= lend_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign lane_ways   = ways_reg;
    assign lane_valid  = lvalid_reg;
    assign parse_error = perr_reg;
    assign list_end    = lend_reg;

endmodule

>>> tb/lane_tag_keyword_parser_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for lane_tag_keyword_parser_core: lanes strings go in byte by byte
// and every lane result is checked against a parser model kept in this file.
// Depends on ltkp_pkg and the core RTL.
module lane_tag_keyword_parser_core_test;

    localparam int N_WORDS       = 15;
    localparam int ITEM_TARGET   = 1400;
    localparam int TAIL_ITEMS    = 150;
    localparam int LONG_HOLD     = 150;
    localparam int PAUSE_AFTER   = 700;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    localparam ltkp_pkg::byte_t CH_LC_A  = 8'h61;
    localparam ltkp_pkg::byte_t CH_LC_Z  = 8'h7A;
    localparam ltkp_pkg::byte_t CH_UNDER = 8'h5F;

    typedef struct packed {
        ltkp_pkg::byte_t ch;
        logic            present;
        logic            last;
    } text_item_t;

    typedef struct packed {
        ltkp_pkg::ways_t ways;
        logic            valid;
        logic            err;
        logic            fin;
    } lane_result_t;

    // Keywords and the direction bits each one sets
    string word_text [N_WORDS] = '{
        "", "through", "left", "right", "none",
        string'({"sharp_", "left"}), string'({"slight_", "left"}),
        string'({"merge_to_", "right"}), string'({"merge_to_", "left"}),
        string'({"slight_", "right"}), string'({"sharp_", "right"}),
        "reverse", string'({"next_", "right"}),
        string'({"slide_", "left"}), string'({"slide_", "right"})
    };
    ltkp_pkg::ways_t word_ways [N_WORDS] = '{
        12'h001, 12'h002, 12'h004, 12'h008, 12'h001, 12'h010, 12'h020,
        12'h040, 12'h080, 12'h100, 12'h200, 12'hC00, 12'h008, 12'h002, 12'h002
    };

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            in_valid     = 1'b0;
    logic            in_ready;
    ltkp_pkg::byte_t char_byte    = '0;
    logic            char_present = 1'b0;
    logic            string_end   = 1'b0;
    logic            out_valid;
    logic            out_ready    = 1'b0;
    ltkp_pkg::ways_t lane_ways;
    logic            lane_valid;
    logic            parse_error;
    logic            list_end;

    text_item_t   pending_q [$];
    lane_result_t lane_expect_q [$];

    int items_made     = 0;
    int total_items    = 0;
    int items_accepted = 0;
    int fail_count     = 0;
    int str_start      = 0;

    // Parser state as seen by the model
    ltkp_pkg::kw_mask_t cand_mask;
    logic [3:0]         tok_len;
    ltkp_pkg::ways_t    lane_acc;
    bit                 bad_token;
    bit                 any_byte;

    lane_tag_keyword_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_byte    (char_byte),
        .char_present (char_present),
        .string_end   (string_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lane_ways    (lane_ways),
        .lane_valid   (lane_valid),
        .parse_error  (parse_error),
        .list_end     (list_end)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------- model

    task automatic clear_token();
        cand_mask = '1;
        tok_len   = '0;
    endtask

    task automatic clear_parse();
        clear_token();
        lane_acc  = '0;
        bad_token = 1'b0;
        any_byte  = 1'b0;
    endtask

    // Narrow the candidate set by one kept character; length saturates at 15
    task automatic step_token(input ltkp_pkg::byte_t c);
        ltkp_pkg::kw_mask_t keep;
        keep = '0;
        for (int k = 0; k < N_WORDS; k++)
        begin
            if (cand_mask[k] && int'(tok_len) < word_text[k].len()
                && word_text[k][tok_len] == c)
                keep[k] = 1'b1;
        end
        cand_mask = keep;
        if (tok_len != 4'hF)
            tok_len = tok_len + 4'd1;
    endtask

    // Close the token: OR in every exact match, flag the string if none
    task automatic close_token();
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < N_WORDS; k++)
        begin
            if (cand_mask[k] && word_text[k].len() == int'(tok_len))
            begin
                lane_acc = lane_acc | word_ways[k];
                hit      = 1'b1;
            end
        end
        clear_token();
        if (!hit)
            bad_token = 1'b1;
    endtask

    task automatic parse_item(input text_item_t it, output bit emits, output lane_result_t res);
        ltkp_pkg::byte_t c;
        bit              lane_out;
        c        = it.ch;
        emits    = 1'b0;
        res      = '0;
        lane_out = 1'b0;
        if (!bad_token && it.present)
        begin
            any_byte = 1'b1;
            if (c == ltkp_pkg::CH_BAR || c == ltkp_pkg::CH_SEMI)
            begin
                close_token();
                if (!bad_token && c == ltkp_pkg::CH_BAR)
                begin
                    emits     = 1'b1;
                    lane_out  = 1'b1;
                    res.ways  = lane_acc;
                    res.valid = 1'b1;
                    res.fin   = it.last;
                    lane_acc  = '0;
                    if (it.last)
                        clear_parse();
                end
            end
            else if (c != ltkp_pkg::CH_SPACE
                     && (c < ltkp_pkg::CH_TAB || c > ltkp_pkg::CH_CR))
            begin
                if (c >= ltkp_pkg::CH_UC_A && c <= ltkp_pkg::CH_UC_Z)
                    c = c + ltkp_pkg::CASE_OFS;
                step_token(c);
            end
        end
        // End of string: error, empty list or the final lane
        if (!lane_out && it.last)
        begin
            emits   = 1'b1;
            res.fin = 1'b1;
            if (bad_token)
                res.err = 1'b1;
            else if (any_byte)
            begin
                close_token();
                if (bad_token)
                    res.err = 1'b1;
                else
                begin
                    res.ways  = lane_acc;
                    res.valid = 1'b1;
                end
            end
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------- stimulus

    task automatic push_raw(input ltkp_pkg::byte_t c, input logic present, input logic last);
        text_item_t it;
        it.ch      = c;
        it.present = present;
        it.last    = last;
        pending_q  = {pending_q, it};
        if (present || last)
            items_made++;
    endtask

    task automatic push_marker();
        push_raw(ltkp_pkg::byte_t'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // One string byte, with the odd idle item or whitespace in front
    task automatic push_char(input ltkp_pkg::byte_t c);
        if ($urandom_range(0, 99) < 4)
            push_raw(ltkp_pkg::byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
        if ($urandom_range(0, 99) < 8)
        begin
            if ($urandom_range(0, 1) == 0)
                push_raw(ltkp_pkg::CH_SPACE, 1'b1, 1'b0);
            else
                push_raw(ltkp_pkg::byte_t'(ltkp_pkg::CH_TAB + $urandom_range(0, 4)),
                         1'b1, 1'b0);
        end
        push_raw(c, 1'b1, 1'b0);
    endtask

    task automatic push_exact(input string s);
        for (int i = 0; i < s.len(); i++)
            push_raw(s[i], 1'b1, 1'b0);
    endtask

    // Word with random upper case letters
    task automatic push_word(input string w);
        ltkp_pkg::byte_t c;
        for (int i = 0; i < w.len(); i++)
        begin
            c = w[i];
            if (c >= CH_LC_A && c <= CH_LC_Z && $urandom_range(0, 2) == 0)
                c = c - ltkp_pkg::CASE_OFS;
            push_char(c);
        end
    endtask

    task automatic push_letter();
        if ($urandom_range(0, 7) == 0)
            push_char(CH_UNDER);
        else
            push_char(ltkp_pkg::byte_t'(CH_LC_A + $urandom_range(0, 25)));
    endtask

    // Put the end flag on the string's last item, or add a bare end marker
    task automatic mark_last();
        if (pending_q.size() == str_start)
            push_marker();
        else
            pending_q[pending_q.size() - 1].last = 1'b1;
    endtask

    task automatic random_token(input bit noisy);
        int    kind;
        string w;
        kind = noisy ? int'($urandom_range(0, 99)) : 0;
        if (kind < 70)
            push_word(word_text[$urandom_range(0, N_WORDS - 1)]);
        else if (kind < 80)
        begin
            // near miss: keyword cut short or run on
            w = word_text[$urandom_range(1, N_WORDS - 1)];
            if ($urandom_range(0, 1) == 0)
                push_word(w.substr(0, w.len() - 2));
            else
            begin
                push_word(w);
                push_letter();
            end
        end
        else if (kind < 88)
        begin
            // long token, past the saturation point of the position
            if ($urandom_range(0, 1) == 0)
                push_word(word_text[7]);
            else
                repeat (14)
                    push_letter();
            repeat ($urandom_range(1, 5))
                push_letter();
        end
        else if (kind < 94)
            repeat ($urandom_range(1, 5))
                push_letter();
        else
            push_char(ltkp_pkg::byte_t'($urandom_range(0, 255)));
    endtask

    task automatic random_string();
        bit noisy;
        int lanes;
        int toks;
        str_start = pending_q.size();
        if ($urandom_range(0, 99) < 4)
            push_marker();
        else
        begin
            noisy = ($urandom_range(0, 99) < 20);
            lanes = $urandom_range(1, 5);
            for (int l = 0; l < lanes; l++)
            begin
                toks = $urandom_range(1, 3);
                for (int t = 0; t < toks; t++)
                begin
                    if (t > 0)
                        push_char(ltkp_pkg::CH_SEMI);
                    random_token(noisy);
                end
                if (l < lanes - 1)
                    push_char(ltkp_pkg::CH_BAR);
            end
            // four ways to end a string
            case ($urandom_range(0, 3))
                0: mark_last();
                1: push_marker();
                2: push_raw(ltkp_pkg::CH_BAR, 1'b1, 1'b1);
                default:
                begin
                    push_char(ltkp_pkg::CH_BAR);
                    push_marker();
                end
            endcase
        end
    endtask

    initial
    begin
        clear_parse();

        // empty string
        push_marker();
        // separator carried with the end
        push_exact("Left");
        push_raw(ltkp_pkg::CH_BAR, 1'b1, 1'b1);
        // unknown token, later bytes ignored
        push_exact("x|left");
        push_marker();
        // byte outside ASCII as the whole string
        push_raw(8'hFF, 1'b1, 1'b1);
        // idle item
        push_raw(8'hA5, 1'b0, 1'b0);
        // empty tokens mean none
        push_exact(";");
        push_marker();
        // bare end after a separator gives the trailing empty lane
        push_exact("|");
        push_marker();
        // whitespace and upper case, end on the last letter
        str_start = pending_q.size();
        push_exact(" Reverse");
        mark_last();

        while (items_made < ITEM_TARGET)
            random_string();
        total_items = pending_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (items_accepted != total_items || lane_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("lane_tag_keyword_parser_core test passed");
        else
            $display("lane_tag_keyword_parser_core test failed");
        $finish;
    end

    // --------------------------------------------------------------- driver

    always @(posedge clk)
    begin : byte_driver
        text_item_t   it;
        lane_result_t res;
        bit           emits;
        int           send_gap;
        bit           drain_pause;
        bit           pause_done;
        if (rst_n)
        begin
            // item taken: work out what it causes
            if (in_valid && in_ready)
            begin
                it.ch      = char_byte;
                it.present = char_present;
                it.last    = string_end;
                parse_item(it, emits, res);
                if (emits)
                begin
                    lane_expect_q = {lane_expect_q, res};
                    if (items_accepted >= PAUSE_AFTER && !pause_done)
                    begin
                        drain_pause = 1'b1;
                        pause_done  = 1'b1;
                    end
                end
                items_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (drain_pause && lane_expect_q.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    drain_pause = 1'b0;
                    if (send_gap > 0)
                    begin
                        send_gap--;
                        in_valid <= 1'b0;
                    end
                    else if (pending_q.size() == 0)
                        in_valid <= 1'b0;
                    else if ((total_items - items_accepted) >= TAIL_ITEMS
                             && $urandom_range(0, 99) < 6)
                    begin
                        send_gap = $urandom_range(1, 19) - 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        it = pending_q.pop_front();
                        in_valid     <= 1'b1;
                        char_byte    <= it.ch;
                        char_present <= it.present;
                        string_end   <= it.last;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------- receiver

    always @(posedge clk)
    begin : result_sink
        int  ready_gap;
        bit  long_done;
        if (rst_n)
        begin
            // one long hold so the block fills and backs up its input
            if (!long_done && items_accepted >= 300)
            begin
                long_done = 1'b1;
                ready_gap = LONG_HOLD;
            end
            if (ready_gap > 0)
            begin
                ready_gap--;
                out_ready <= 1'b0;
            end
            else if ((total_items - items_accepted) >= TAIL_ITEMS
                     && $urandom_range(0, 99) < 6)
            begin
                ready_gap = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // -------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : result_check
        lane_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lane_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result ways=%h valid=%b err=%b end=%b",
                         $time, lane_ways, lane_valid, parse_error, list_end);
                fail_count++;
            end
            else
            begin
                want = lane_expect_q.pop_front();
                if (lane_ways !== want.ways)
                begin
                    $display("%0t: lane_ways expected %h got %h", $time, want.ways, lane_ways);
                    fail_count++;
                end
                if (lane_valid !== want.valid)
                begin
                    $display("%0t: lane_valid expected %b got %b",
                             $time, want.valid, lane_valid);
                    fail_count++;
                end
                if (parse_error !== want.err)
                begin
                    $display("%0t: parse_error expected %b got %b",
                             $time, want.err, parse_error);
                    fail_count++;
                end
                if (list_end !== want.fin)
                begin
                    $display("%0t: list_end expected %b got %b", $time, want.fin, list_end);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin : stall_watch
        int stall_cycles;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("lane_tag_keyword_parser_core test failed");
                $finish;
            end
        end
    end

endmodule
